>>> rtl/core/bkl_pkg.sv
`default_nettype none

package bkl_pkg;

    // Field widths
    localparam int LEVEL_W = 7;
    localparam int STEP_W  = 5;
    localparam int IDLE_W  = 16;
    localparam int OP_W    = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_ACTIVITY = 3'd1;
    localparam logic [OP_W-1:0] OP_INC      = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC      = 3'd3;
    localparam logic [OP_W-1:0] OP_SET      = 3'd4;
    localparam logic [OP_W-1:0] OP_ENABLE   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_TABLET = 1'b0;
    localparam logic CFG_IDLE   = 1'b1;

    // Level change per increment or decrement
    localparam logic [LEVEL_W-1:0] LEVEL_STEP = 7'd10;

    // Reset value of the idle timeout
    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 16'd200;

    typedef logic [LEVEL_W-1:0] t_level;

    typedef struct packed {
        t_level drive_level;
        t_level user_level;
        logic   enabled;
    } t_result;

    // floor(x / 6) for x < 128 by reciprocal: (x * 43) >> 8
    function automatic logic [STEP_W-1:0] div6(input logic [LEVEL_W-1:0] x);
        logic [LEVEL_W+5:0] prod;
        begin
            prod = {6'd0, x} * 13'd43;
            div6 = prod[LEVEL_W+5:8];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/backlight_fade_idle_controller.sv
// Backlight level controller with fade and idle dimming.
// Each result is registered in the result register, or in the skid entry when that register is held by a stall.
// Throughput: one item per cycle while the skid entry is empty; the update is one short pass of logic.
// A two-entry output stage (result register plus skid) keeps input open while a result waits.
// Reset (synchronous, active low): level 0, enabled, timeout 200, output stage empty.
`default_nettype none

module backlight_fade_idle_controller #(
    parameter int MAX_LEVEL = 100
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // Configuration
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_index,
    input  wire [bkl_pkg::IDLE_W-1:0]  i_cfg_data,
    // Input channel
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire [bkl_pkg::OP_W-1:0]    i_opcode,
    input  wire [bkl_pkg::LEVEL_W-1:0] i_value,
    input  wire                        i_laptop_posture,
    // Output channel
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [bkl_pkg::LEVEL_W-1:0] o_drive_level,
    output logic [bkl_pkg::LEVEL_W-1:0] o_user_level,
    output logic                       o_enabled
);
    import bkl_pkg::*;

    localparam t_level MAX_LV = t_level'(MAX_LEVEL);

    // Configuration registers
    logic              r_tablet;
    logic [IDLE_W-1:0] r_timeout;

    // Control state
    t_level            r_applied, n_applied;
    t_level            r_target, n_target;
    logic [STEP_W-1:0] r_step, n_step;
    t_level            r_chosen, n_chosen;
    logic              r_enable, n_enable;
    logic              r_last_laptop, n_last_laptop;
    logic [IDLE_W-1:0] r_idle, n_idle;

    // Output stage
    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    logic    accept, take;
    logic    res_vld;
    t_result res;

    // Fade start helper signals
    logic       fade_go;
    t_level     fade_to;
    t_level     diff;
    logic       apply_go;
    t_level     apply_lv;
    logic       laptop;
    logic [LEVEL_W:0] sum_up, sum_lo;
    logic [IDLE_W-1:0] idle_inc;
    t_level     mv;

    assign accept = i_in_valid && !o_in_stall;
    assign take   = r_out_vld && !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tablet  <= 1'b0;
            r_timeout <= IDLE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TABLET: r_tablet  <= i_cfg_data[0];
                CFG_IDLE:   r_timeout <= i_cfg_data;
                default:    r_tablet  <= r_tablet;
            endcase
        end
    end

    // Item update
    always_comb begin
        n_applied     = r_applied;
        n_target      = r_target;
        n_step        = r_step;
        n_chosen      = r_chosen;
        n_enable      = r_enable;
        n_last_laptop = r_last_laptop;
        n_idle        = r_idle;
        fade_go       = 1'b0;
        fade_to       = '0;
        apply_go      = 1'b0;
        apply_lv      = r_applied;
        laptop        = r_tablet ? i_laptop_posture : 1'b1;
        idle_inc      = (r_idle == {IDLE_W{1'b1}}) ? r_idle : r_idle + 1'b1;
        sum_up        = {1'b0, r_applied} + {3'd0, r_step};
        sum_lo        = {1'b0, r_target} + {3'd0, r_step};
        mv            = r_applied;

        if (r_applied < r_target) begin
            mv = (sum_up > {1'b0, r_target}) ? r_target : sum_up[LEVEL_W-1:0];
        end else if (r_applied > r_target) begin
            mv = ({1'b0, r_applied} < sum_lo) ? r_target : r_applied - t_level'(r_step);
        end

        case (i_opcode)
            OP_TICK: begin
                n_idle = idle_inc;
                if (r_applied == r_target && r_last_laptop == laptop) begin
                    if (idle_inc > r_timeout) begin
                        fade_go = r_enable;
                        fade_to = '0;
                    end else if (r_chosen != '0 && r_applied == '0) begin
                        fade_go = r_enable;
                        fade_to = r_chosen;
                    end
                end else begin
                    apply_go = 1'b1;
                    apply_lv = mv;
                end
            end
            OP_ACTIVITY: begin
                n_idle = '0;
            end
            OP_INC: begin
                fade_go = 1'b1;
                fade_to = ({1'b0, r_target} + {1'b0, LEVEL_STEP} > {1'b0, MAX_LV}) ?
                          MAX_LV : r_target + LEVEL_STEP;
            end
            OP_DEC: begin
                fade_go = 1'b1;
                fade_to = (r_target >= LEVEL_STEP) ? r_target - LEVEL_STEP : '0;
            end
            OP_SET: begin
                fade_go = 1'b1;
                fade_to = (i_value > MAX_LV) ? MAX_LV : i_value;
            end
            OP_ENABLE: begin
                n_enable = i_value[0];
                apply_go = 1'b1;
                apply_lv = r_applied;
            end
            default: begin
                apply_go = 1'b0;
            end
        endcase

        // User choice: increment, decrement, set
        if (i_opcode == OP_INC || i_opcode == OP_DEC || i_opcode == OP_SET) begin
            n_chosen = fade_to;
            n_enable = 1'b1;
        end

        // Fade start from the current applied level
        diff = (r_applied > fade_to) ? r_applied - fade_to : fade_to - r_applied;
        if (fade_go) begin
            n_target = fade_to;
            n_step   = (div6(diff) == '0) ? STEP_W'(1) : div6(diff);
        end

        // Level application and its result
        if (apply_go) begin
            n_applied     = (apply_lv > MAX_LV) ? MAX_LV : apply_lv;
            n_last_laptop = laptop;
        end
        res_vld          = accept && apply_go;
        res.drive_level  = (n_enable && laptop) ? n_applied : '0;
        res.user_level   = n_chosen;
        res.enabled      = n_enable;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_applied     <= '0;
            r_target      <= '0;
            r_step        <= '0;
            r_chosen      <= '0;
            r_enable      <= 1'b1;
            r_last_laptop <= 1'b1;
            r_idle        <= '0;
        end else if (accept) begin
            r_applied     <= n_applied;
            r_target      <= n_target;
            r_step        <= n_step;
            r_chosen      <= n_chosen;
            r_enable      <= n_enable;
            r_last_laptop <= n_last_laptop;
            r_idle        <= n_idle;
        end
    end

    // Output stage: result register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (res_vld) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld  <= r_skid_vld;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            if (!r_out_vld || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (take && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_in_stall    = r_skid_vld;
    assign o_out_valid   = r_out_vld;
    assign o_drive_level = r_out.drive_level;
    assign o_user_level  = r_out.user_level;
    assign o_enabled     = r_out.enabled;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bkl_pkg::*;

    localparam int LEVEL_MAX = 100;

    // Opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Cycles with nothing accepted, delivered or configured before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    // Cycles to let the block settle after its last result
    localparam int SETTLE_CYCLES = 4;

    // Predicts backlight drive items and holds them until the block delivers them
    class fade_scoreboard;
        bit                tablet_mode;
        logic [IDLE_W-1:0] idle_limit;
        t_level            level_now;
        t_level            level_goal;
        logic [STEP_W-1:0] fade_stride;
        t_level            level_user;
        bit                en_flag;
        bit                posture_last;
        logic [IDLE_W-1:0] idle_ticks;
        t_result           drive_expected[$];
        int                errors;

        function new();
            tablet_mode  = 1'b0;
            idle_limit   = IDLE_TIMEOUT_RST;
            level_now    = '0;
            level_goal   = '0;
            fade_stride  = '0;
            level_user   = '0;
            en_flag      = 1'b1;
            posture_last = 1'b1;
            idle_ticks   = '0;
            errors       = 0;
        endfunction

        function int cap(int v);
            return (v > LEVEL_MAX) ? LEVEL_MAX : v;
        endfunction

        function void write_reg(logic idx, logic [IDLE_W-1:0] data);
            if (idx == CFG_TABLET)
                tablet_mode = data[0];
            else
                idle_limit = data;
        endfunction

        // Step is a sixth of the distance at fade start, never below one
        function void begin_fade(int target);
            int diff;
            diff = (int'(level_now) > target) ? int'(level_now) - target
                                               : target - int'(level_now);
            fade_stride = STEP_W'((diff / 6 == 0) ? 1 : diff / 6);
            level_goal  = t_level'(target);
        endfunction

        function void choose(int lvl);
            level_user = t_level'(lvl);
            en_flag    = 1'b1;
            begin_fade(lvl);
        endfunction

        function void apply_drive(int lvl, bit lap);
            t_result r;
            level_now      = t_level'(cap(lvl));
            posture_last   = lap;
            r.drive_level  = (en_flag && lap) ? level_now : '0;
            r.user_level   = level_user;
            r.enabled      = en_flag;
            drive_expected.push_back(r);
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] val, bit pos);
            bit lap;
            int d;
            int t;
            lap = tablet_mode ? pos : 1'b1;
            case (op)
                OP_TICK: begin
                    if (idle_ticks != '1)
                        idle_ticks++;
                    // settled: maybe start the idle fade or the fade back up
                    if (level_now == level_goal && posture_last == lap) begin
                        if (idle_ticks > idle_limit) begin
                            if (en_flag)
                                begin_fade(0);
                        end else if (level_user != 0 && level_now == 0 && en_flag) begin
                            begin_fade(int'(level_user));
                        end
                    end else begin
                        d = int'(level_now);
                        t = int'(level_goal);
                        if (d < t)
                            d = (d + int'(fade_stride) > t) ? t : d + int'(fade_stride);
                        else if (d > t)
                            d = (d < t + int'(fade_stride)) ? t : d - int'(fade_stride);
                        apply_drive(d, lap);
                    end
                end
                OP_ACTIVITY: idle_ticks = '0;
                OP_INC:      choose(cap(int'(level_goal) + int'(LEVEL_STEP)));
                OP_DEC:      choose((level_goal >= LEVEL_STEP) ?
                                    int'(level_goal - LEVEL_STEP) : 0);
                OP_SET:      choose(cap(int'(val)));
                OP_ENABLE: begin
                    en_flag = val[0];
                    apply_drive(int'(level_now), lap);
                end
                default: ;
            endcase
        endfunction

        function void check_drive(t_result got);
            t_result want;
            if (drive_expected.size() == 0) begin
                $error("unexpected drive item: drive_level %0d user_level %0d enabled %0d",
                       got.drive_level, got.user_level, got.enabled);
                errors++;
                return;
            end
            want = drive_expected.pop_front();
            if (got.drive_level !== want.drive_level) begin
                $error("drive_level: expected %0d, got %0d", want.drive_level, got.drive_level);
                errors++;
            end
            if (got.user_level !== want.user_level) begin
                $error("user_level: expected %0d, got %0d", want.user_level, got.user_level);
                errors++;
            end
            if (got.enabled !== want.enabled) begin
                $error("enabled: expected %0d, got %0d", want.enabled, got.enabled);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    logic                i_cfg_index      = 1'b0;
    logic [IDLE_W-1:0]   i_cfg_data       = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_opcode         = '0;
    logic [LEVEL_W-1:0]  i_value          = '0;
    logic                i_laptop_posture = 1'b1;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [LEVEL_W-1:0]  o_drive_level;
    logic [LEVEL_W-1:0]  o_user_level;
    logic                o_enabled;

    fade_scoreboard sb = new();
    bit             quiet = 1'b0;
    int             idle_cycles = 0;

    backlight_fade_idle_controller #(
        .MAX_LEVEL(LEVEL_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .i_laptop_posture (i_laptop_posture),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_level    (o_drive_level),
        .o_user_level     (o_user_level),
        .o_enabled        (o_enabled)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end

    // Check each delivered item
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.drive_level = o_drive_level;
            got.user_level  = o_user_level;
            got.enabled     = o_enabled;
            sb.check_drive(got);
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("backlight_fade_idle_controller test failed");
                $finish;
            end
        end
    end

    // Starts and ends at a falling edge
    task automatic push_item(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] val, bit pos);
        while (!quiet && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_value          <= val;
        i_laptop_posture <= pos;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, val, pos);
        @(negedge i_clk);
    endtask

    // Hold input off until every predicted item has come out
    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        while (sb.drive_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_config(bit tablet, logic [IDLE_W-1:0] idle);
        settle_outputs();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TABLET;
        i_cfg_data  <= {{(IDLE_W-1){1'b0}}, tablet};
        @(posedge i_clk);
        sb.write_reg(CFG_TABLET, {{(IDLE_W-1){1'b0}}, tablet});
        @(negedge i_clk);
        i_cfg_index <= CFG_IDLE;
        i_cfg_data  <= idle;
        @(posedge i_clk);
        sb.write_reg(CFG_IDLE, idle);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly ticks so fades run to completion; posture flips now and then
    task automatic random_item(inout bit pos, output bit counted);
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] val;
        pick    = $urandom_range(0, 99);
        val     = LEVEL_W'($urandom_range(0, 127));
        counted = 1'b1;
        if ($urandom_range(0, 99) < 4)
            pos = ~pos;
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 65)
            op = OP_ACTIVITY;
        else if (pick < 73)
            op = OP_INC;
        else if (pick < 81)
            op = OP_DEC;
        else if (pick < 89)
            op = OP_SET;
        else if (pick < 97) begin
            op     = OP_ENABLE;
            val[0] = ($urandom_range(0, 3) != 0);
        end else begin
            op      = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            counted = 1'b0;
        end
        push_item(op, val, pos);
    endtask

    task automatic run_phase(bit tablet, logic [IDLE_W-1:0] idle, int count, bit pause_mid);
        int n;
        bit pos;
        bit counted;
        n   = 0;
        pos = 1'b1;
        load_config(tablet, idle);
        while (n < count) begin
            random_item(pos, counted);
            if (counted)
                n++;
            if (pause_mid && n == count / 2 && counted)
                settle_outputs();
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: fade up from a saturated set, posture gating, enable, spares, idle fade
        load_config(1'b1, 16'd3);
        push_item(OP_SET, 7'd127, 1'b1);
        repeat (7) push_item(OP_TICK, 7'd0, 1'b1);
        push_item(OP_INC, 7'd0, 1'b1);
        push_item(OP_TICK, 7'd0, 1'b0);
        push_item(OP_ENABLE, 7'd0, 1'b0);
        push_item(OP_ENABLE, 7'd1, 1'b1);
        push_item(OP_DEC, 7'd0, 1'b1);
        repeat (2) push_item(OP_TICK, 7'd0, 1'b1);
        push_item(OP_SET, 7'd0, 1'b1);
        push_item(OP_SPARE_6, 7'd127, 1'b0);
        push_item(OP_SPARE_7, 7'd0, 1'b1);
        repeat (4) push_item(OP_TICK, 7'd0, 1'b1);
        push_item(OP_ACTIVITY, 7'd0, 1'b1);
        push_item(OP_TICK, 7'd0, 1'b1);

        // Random phases across the register settings
        run_phase(1'b1, 16'd0, 105, 1'b0);
        run_phase(1'b0, 16'd5, 105, 1'b1);
        quiet = 1'b1;
        run_phase(1'b1, 16'd30, 105, 1'b0);
        quiet = 1'b0;
        run_phase(1'b1, 16'hFFFF, 105, 1'b0);
        run_phase(1'b0, 16'd200, 105, 1'b0);

        settle_outputs();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.drive_expected.size() == 0)
            $display("backlight_fade_idle_controller test passed");
        else
            $display("backlight_fade_idle_controller test failed");
        $finish;
    end

endmodule
